// ===== design/drpu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the dead-reckoning pose update block: widths, codes, angle constants,
// CORDIC arctangent table and the sequencer state type. No dependencies.
package drpu_pkg;

  localparam int unsigned POS_W        = 32;
  localparam int unsigned HEAD_W       = 25;
  localparam int unsigned CIRC_W       = 24;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned ANG_FRAC     = 24;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned ATAN_W       = 30;
  localparam int unsigned ANG_W        = 35;

  localparam logic signed [POS_W-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic signed [ANG_W-1:0] FULL_ANG    = 35'sd6039797760;
  localparam logic signed [ANG_W-1:0] HALF_ANG    = 35'sd3019898880;
  localparam logic signed [ANG_W-1:0] QUARTER_ANG = 35'sd1509949440;

  localparam logic [CIRC_W-1:0] TRACKER_CIRC_RST = 24'd411775;
  localparam logic [CIRC_W-1:0] DRIVE_CIRC_RST   = 24'd566191;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_SET    = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_TRACKER  = 2'd0,
    CFG_TRACKER_CIRC = 2'd1,
    CFG_DRIVE_CIRC   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FOLD,
    ST_ROTATE,
    ST_SETUP,
    ST_PRODUCT,
    ST_ACCUM,
    ST_FINISH
  } state_e;

  // arctangent of 2^-i in degrees, Q.24
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/drpu_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data with valid/ready.
// Depends on drpu_pkg.
interface drpu_cfg_if import drpu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [CIRC_W-1:0]    data;

  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== design/drpu_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one sample or set-pose word with valid/ready.
// Depends on drpu_pkg.
interface drpu_in_if import drpu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [POS_W-1:0] tracker_rotations;
  logic signed [POS_W-1:0] left_rotations;
  logic signed [POS_W-1:0] right_rotations;
  logic [HEAD_W-1:0]       heading_deg;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic [HEAD_W-1:0]       new_theta;

  modport source (output valid, output cmd, output tracker_rotations, output left_rotations,
                  output right_rotations, output heading_deg, output new_x, output new_y,
                  output new_theta, input ready);
  modport sink (input valid, input cmd, input tracker_rotations, input left_rotations,
                input right_rotations, input heading_deg, input new_x, input new_y,
                input new_theta, output ready);
endinterface

// ===== design/drpu_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one pose word with valid/ready.
// Depends on drpu_pkg.
interface drpu_out_if import drpu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pose_x;
  logic signed [POS_W-1:0] pose_y;
  logic [HEAD_W-1:0]       pose_theta;

  modport source (output valid, output pose_x, output pose_y, output pose_theta, input ready);
  modport sink (input valid, input pose_x, input pose_y, input pose_theta, output ready);
endinterface

// ===== design/dead_reckoning_pose_update.sv =====
`timescale 1ns / 1ps
// Dead-reckoning pose update: bit-serial distance and pose multipliers, iterative CORDIC.
// Depends on drpu_pkg, drpu_cfg_if, drpu_in_if, drpu_out_if.
//
//   channel  dir  fields                                      accepted when
//   cfg_i    in   idx, data                                   valid & ready
//   in_i     in   cmd, rotations, heading_deg, new_x/y/theta  valid & ready
//   out_o    out  pose_x, pose_y, pose_theta                  valid & ready
//
// Sample word: heading reduction, 24 CORDIC iterations, 32-step serial multiply.
// Set-pose word: goes straight from idle to the finish state, which loads the output.
// Reset returns config to defaults and pose/previous distance to zero; no clearing pass.
// A new word is taken whenever the sequencer is idle, even while a result waits in out_o;
// a finished result holds in the sequencer until the output register frees.
module dead_reckoning_pose_update import drpu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  drpu_cfg_if.sink           cfg_i,
  drpu_in_if.sink            in_i,
  drpu_out_if.source         out_o
);

  localparam int unsigned SHIFT = ANG_FRAC - FRAC_BITS;
  localparam int unsigned AW    = HEAD_W + SHIFT;
  localparam int unsigned RW    = ((AW > 33) ? AW : 33) + 1;
  localparam int unsigned RS    = (AW > 32) ? AW - 31 : 1;
  localparam int unsigned FW    = POS_W + CIRC_W;
  localparam int unsigned PW    = 2 * POS_W;

  localparam logic [RW-1:0]     FULL_RW   = RW'(FULL_ANG);
  localparam logic [STEP_W-1:0] RED_LAST  = STEP_W'(RS - 1);
  localparam logic [STEP_W-1:0] ROT_LAST  = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(POS_W - 1);
  localparam logic [STEP_W-1:0] FWD_DONE  = STEP_W'(CIRC_W);

  state_e                   state_q, state_d;
  logic [STEP_W-1:0]        cnt_q, cnt_d;
  logic [STEP_W-1:0]        fwd_cnt_q, fwd_cnt_d;
  logic                     use_tracker_q, use_tracker_d;
  logic [CIRC_W-1:0]        tracker_circ_q, tracker_circ_d;
  logic [CIRC_W-1:0]        drive_circ_q, drive_circ_d;
  logic [POS_W-1:0]         prev_fwd_q, prev_fwd_d;
  logic [POS_W-1:0]         acc_x_q, acc_x_d;
  logic [POS_W-1:0]         acc_y_q, acc_y_d;
  logic [HEAD_W-1:0]        acc_theta_q, acc_theta_d;
  logic                     out_valid_q, out_valid_d;

  logic signed [POS_W-1:0]  rot_q, rot_d;
  logic [CIRC_W-1:0]        circ_q, circ_d;
  logic signed [POS_W:0]    fwd_hi_q, fwd_hi_d;
  logic [CIRC_W-1:0]        fwd_lo_q, fwd_lo_d;
  logic [HEAD_W-1:0]        heading_q, heading_d;
  logic [RW-1:0]            rem_q, rem_d;
  logic                     neg_q, neg_d;
  logic signed [POS_W-1:0]  cx_q, cx_d;
  logic signed [POS_W-1:0]  cy_q, cy_d;
  logic signed [ANG_W-1:0]  cz_q, cz_d;
  logic signed [POS_W-1:0]  d_q, d_d;
  logic [POS_W-1:0]         ms_q, ms_d;
  logic [POS_W-1:0]         mc_q, mc_d;
  logic signed [POS_W:0]    px_hi_q, px_hi_d;
  logic [POS_W-1:0]         px_lo_q, px_lo_d;
  logic signed [POS_W:0]    py_hi_q, py_hi_d;
  logic [POS_W-1:0]         py_lo_q, py_lo_d;
  logic [POS_W-1:0]         out_x_q, out_x_d;
  logic [POS_W-1:0]         out_y_q, out_y_d;
  logic [HEAD_W-1:0]        out_theta_q, out_theta_d;

  logic                     in_acc;
  logic signed [POS_W:0]    mean_sum;
  logic signed [POS_W:0]    fwd_sum;
  logic [FW-1:0]            fwd_prod;
  logic [POS_W-1:0]         fwd_cur;
  logic [STEP_W-1:0]        red_k;
  logic [RW-1:0]            full_sh;
  logic signed [ANG_W-1:0]  fa0, fa1;
  logic signed [POS_W-1:0]  xs, ys;
  logic signed [ANG_W-1:0]  atan_s;
  logic                     mul_last;
  logic signed [POS_W:0]    dext, add_x, add_y, sum_x, sum_y;
  logic [PW-1:0]            prod_x, prod_y;

  assign in_acc      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.pose_x     = out_x_q;
  assign out_o.pose_y     = out_y_q;
  assign out_o.pose_theta = out_theta_q;

  assign mean_sum = {in_i.left_rotations[POS_W-1], in_i.left_rotations}
                  + {in_i.right_rotations[POS_W-1], in_i.right_rotations};

  assign fwd_sum  = fwd_hi_q + (circ_q[0] ? {rot_q[POS_W-1], rot_q} : '0);
  assign fwd_prod = {fwd_hi_q[POS_W-1:0], fwd_lo_q};
  assign fwd_cur  = fwd_prod[FRAC_BITS +: POS_W];

  assign red_k   = RED_LAST - cnt_q;
  assign full_sh = FULL_RW << red_k;

  assign fa0 = $signed({2'b00, rem_q[32:0]});
  assign fa1 = (fa0 > HALF_ANG) ? fa0 - FULL_ANG : fa0;

  assign xs     = cx_q >>> cnt_q;
  assign ys     = cy_q >>> cnt_q;
  assign atan_s = $signed({{(ANG_W - ATAN_W){1'b0}}, atan_deg(cnt_q)});

  assign mul_last = (cnt_q == MUL_LAST);
  assign dext     = {d_q[POS_W-1], d_q};
  assign add_x    = ms_q[0] ? (mul_last ? -dext : dext) : '0;
  assign add_y    = mc_q[0] ? (mul_last ? -dext : dext) : '0;
  assign sum_x    = px_hi_q + add_x;
  assign sum_y    = py_hi_q + add_y;
  assign prod_x   = {px_hi_q[POS_W-1:0], px_lo_q};
  assign prod_y   = {py_hi_q[POS_W-1:0], py_lo_q};

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    fwd_cnt_d      = fwd_cnt_q;
    use_tracker_d  = use_tracker_q;
    tracker_circ_d = tracker_circ_q;
    drive_circ_d   = drive_circ_q;
    prev_fwd_d     = prev_fwd_q;
    acc_x_d        = acc_x_q;
    acc_y_d        = acc_y_q;
    acc_theta_d    = acc_theta_q;
    out_valid_d    = out_valid_q;
    rot_d          = rot_q;
    circ_d         = circ_q;
    fwd_hi_d       = fwd_hi_q;
    fwd_lo_d       = fwd_lo_q;
    heading_d      = heading_q;
    rem_d          = rem_q;
    neg_d          = neg_q;
    cx_d           = cx_q;
    cy_d           = cy_q;
    cz_d           = cz_q;
    d_d            = d_q;
    ms_d           = ms_q;
    mc_d           = mc_q;
    px_hi_d        = px_hi_q;
    px_lo_d        = px_lo_q;
    py_hi_d        = py_hi_q;
    py_lo_d        = py_lo_q;
    out_x_d        = out_x_q;
    out_y_d        = out_y_q;
    out_theta_d    = out_theta_q;

    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.idx)
        CFG_USE_TRACKER:  use_tracker_d  = cfg_i.data[0];
        CFG_TRACKER_CIRC: tracker_circ_d = cfg_i.data;
        CFG_DRIVE_CIRC:   drive_circ_d   = cfg_i.data;
        default: ;
      endcase
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // distance multiplier runs alongside reduction and rotation
    if (state_q != ST_IDLE && fwd_cnt_q != FWD_DONE) begin
      fwd_hi_d  = {fwd_sum[POS_W], fwd_sum[POS_W:1]};
      fwd_lo_d  = {fwd_sum[0], fwd_lo_q[CIRC_W-1:1]};
      circ_d    = circ_q >> 1;
      fwd_cnt_d = fwd_cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == CMD_SET) begin
            acc_x_d     = in_i.new_x;
            acc_y_d     = in_i.new_y;
            acc_theta_d = in_i.new_theta;
            state_d     = ST_FINISH;
          end else begin
            rot_d     = use_tracker_q ? in_i.tracker_rotations : mean_sum[POS_W:1];
            circ_d    = use_tracker_q ? tracker_circ_q : drive_circ_q;
            fwd_hi_d  = '0;
            fwd_lo_d  = '0;
            fwd_cnt_d = '0;
            heading_d = in_i.heading_deg;
            rem_d     = {{(RW - HEAD_W){1'b0}}, in_i.heading_deg} << SHIFT;
            cnt_d     = '0;
            state_d   = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (rem_q >= full_sh) begin
          rem_d = rem_q - full_sh;
        end
        if (cnt_q == RED_LAST) begin
          cnt_d   = '0;
          state_d = ST_FOLD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FOLD: begin
        cx_d = CORDIC_GAIN;
        cy_d = '0;
        if (fa1 > QUARTER_ANG) begin
          cz_d  = fa1 - HALF_ANG;
          neg_d = 1'b1;
        end else if (fa1 < -QUARTER_ANG) begin
          cz_d  = fa1 + HALF_ANG;
          neg_d = 1'b1;
        end else begin
          cz_d  = fa1;
          neg_d = 1'b0;
        end
        cnt_d   = '0;
        state_d = ST_ROTATE;
      end
      ST_ROTATE: begin
        if (!cz_q[ANG_W-1]) begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - atan_s;
        end else begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + atan_s;
        end
        if (cnt_q == ROT_LAST) begin
          cnt_d   = '0;
          state_d = ST_SETUP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SETUP: begin
        d_d        = fwd_cur - prev_fwd_q;
        prev_fwd_d = fwd_cur;
        ms_d       = neg_q ? -cy_q : cy_q;
        mc_d       = neg_q ? -cx_q : cx_q;
        px_hi_d    = '0;
        px_lo_d    = '0;
        py_hi_d    = '0;
        py_lo_d    = '0;
        cnt_d      = '0;
        state_d    = ST_PRODUCT;
      end
      ST_PRODUCT: begin
        px_hi_d = {sum_x[POS_W], sum_x[POS_W:1]};
        px_lo_d = {sum_x[0], px_lo_q[POS_W-1:1]};
        py_hi_d = {sum_y[POS_W], sum_y[POS_W:1]};
        py_lo_d = {sum_y[0], py_lo_q[POS_W-1:1]};
        ms_d    = ms_q >> 1;
        mc_d    = mc_q >> 1;
        if (mul_last) begin
          state_d = ST_ACCUM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ACCUM: begin
        acc_x_d     = acc_x_q + prod_x[30 +: POS_W];
        acc_y_d     = acc_y_q + prod_y[30 +: POS_W];
        acc_theta_d = heading_q;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_x_d     = acc_x_q;
          out_y_d     = acc_y_q;
          out_theta_d = acc_theta_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      fwd_cnt_q      <= FWD_DONE;
      use_tracker_q  <= 1'b0;
      tracker_circ_q <= TRACKER_CIRC_RST;
      drive_circ_q   <= DRIVE_CIRC_RST;
      prev_fwd_q     <= '0;
      acc_x_q        <= '0;
      acc_y_q        <= '0;
      acc_theta_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      fwd_cnt_q      <= fwd_cnt_d;
      use_tracker_q  <= use_tracker_d;
      tracker_circ_q <= tracker_circ_d;
      drive_circ_q   <= drive_circ_d;
      prev_fwd_q     <= prev_fwd_d;
      acc_x_q        <= acc_x_d;
      acc_y_q        <= acc_y_d;
      acc_theta_q    <= acc_theta_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_q       <= rot_d;
    circ_q      <= circ_d;
    fwd_hi_q    <= fwd_hi_d;
    fwd_lo_q    <= fwd_lo_d;
    heading_q   <= heading_d;
    rem_q       <= rem_d;
    neg_q       <= neg_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    cz_q        <= cz_d;
    d_q         <= d_d;
    ms_q        <= ms_d;
    mc_q        <= mc_d;
    px_hi_q     <= px_hi_d;
    px_lo_q     <= px_lo_d;
    py_hi_q     <= py_hi_d;
    py_lo_q     <= py_lo_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_theta_q <= out_theta_d;
  end

  a_set_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.cmd == CMD_SET) |=> (state_q == ST_FINISH))
    else $error("set-pose word did not go straight to finish");

  a_fwd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETUP) |-> (fwd_cnt_q == FWD_DONE))
    else $error("distance multiply not finished at setup");

  a_rem_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |-> (rem_q < FULL_RW))
    else $error("heading not reduced below a full turn");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result raised outside finish");

endmodule
